// File: hdl/hbc_pkg.sv
// hbc_pkg: constants and shared types of the heater balance controller
// no dependencies; imported by the interfaces, the datapath units and the top level
`timescale 1ns / 1ps

package hbc_pkg;

  localparam int unsigned TempW   = 16;
  localparam int unsigned DiffW   = TempW + 1;
  localparam int unsigned MagW    = 16;
  localparam int unsigned SqW     = 2 * MagW;
  localparam int unsigned ProdW   = SqW + MagW;
  localparam int unsigned SlopeSh = 9;
  localparam int unsigned WideW   = ProdW + SlopeSh + 2;
  localparam int unsigned IntegW  = 18;
  localparam int unsigned CountW  = 32;
  localparam int unsigned PlanW   = 2;

  localparam int ClampLimit = 32767;
  localparam logic [TempW-1:0] InvalidMark = 16'h8000;
  localparam logic [PlanW-1:0] HeaterOne = 2'b01;
  localparam logic [PlanW-1:0] HeaterTwo = 2'b10;

  typedef struct packed {
    logic tick;
    logic turn_off;
    logic turn_on;
  } plan_cmd_t;

endpackage

// File: hdl/hbc_if.sv
// hbc_if: valid/ready stream interfaces for sample beats and result beats
// depends on hbc_pkg for field widths
`timescale 1ns / 1ps

interface hbc_in_if import hbc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic signed [TempW-1:0] temperature;

  modport source (output valid, output func, output temperature, input ready);
  modport sink   (input valid, input func, input temperature, output ready);
endinterface

interface hbc_out_if import hbc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic        [PlanW-1:0] heater_on;
  logic signed [TempW-1:0] balance;

  modport source (output valid, output heater_on, output balance, input ready);
  modport sink   (input valid, input heater_on, input balance, output ready);
endinterface

// File: hdl/hbc_mul.sv
// hbc_mul: shared unsigned multiplier with a registered product
// depends on hbc_pkg; used by the sequencer for squares and cubes
`timescale 1ns / 1ps

module hbc_mul import hbc_pkg::*; (
  input  logic             clk_i,
  input  logic [SqW-1:0]   op_a_i,
  input  logic [MagW-1:0]  op_b_i,
  output logic [ProdW-1:0] prod_o
);

  logic [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(op_a_i) * ProdW'(op_b_i);
  end

  assign prod_o = prod_q;

endmodule

// File: hdl/hbc_plan.sv
// hbc_plan: heater plan and run counters, turn-on/turn-off selection
// depends on hbc_pkg for plan_cmd_t and widths
`timescale 1ns / 1ps

module hbc_plan import hbc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  plan_cmd_t        cmd_i,
  output logic [PlanW-1:0] plan_o
);

  logic [PlanW-1:0]  plan_q, plan_d;
  logic [CountW-1:0] run_q [PlanW];
  logic [CountW-1:0] run_d [PlanW];

  always_comb begin
    plan_d   = plan_q;
    run_d[0] = run_q[0];
    run_d[1] = run_q[1];
    if (cmd_i.tick) begin
      if (plan_q[0]) run_d[0] = run_q[0] + 1'b1;
      if (plan_q[1]) run_d[1] = run_q[1] + 1'b1;
    end
    if (cmd_i.turn_off) begin
      if (plan_q[1] && (!plan_q[0] || run_q[1] > run_q[0])) begin
        plan_d = plan_q & ~HeaterTwo;
      end else if (plan_q[0]) begin
        plan_d = plan_q & ~HeaterOne;
      end
    end
    if (cmd_i.turn_on) begin
      if (!plan_q[1] && (plan_q[0] || run_q[1] < run_q[0])) begin
        plan_d = plan_q | HeaterTwo;
      end else if (!plan_q[0]) begin
        plan_d = plan_q | HeaterOne;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_q   <= '0;
      run_q[0] <= '0;
      run_q[1] <= '0;
    end else begin
      plan_q   <= plan_d;
      run_q[0] <= run_d[0];
      run_q[1] <= run_d[1];
    end
  end

  assign plan_o = plan_q;

endmodule

// File: hdl/heater_balance_controller_core.sv
// heater_balance_controller_core: sequencer, balance datapath and result register
// depends on hbc_pkg, hbc_if, hbc_mul and hbc_plan
`timescale 1ns / 1ps
//
// Usage: one input channel (in_ch) carries func and temperature beats, one
// output channel (out_ch) carries heater_on and balance, one result beat for
// every input beat. The setpoint is written through cfg_we_i / cfg_wdata_i;
// the user must write it only while the block is idle; the block itself
// does not enforce this. A tick beat (func 0) bumps the run counters of the
// heaters that are on and goes straight to the result step, ST_DONE. A sample
// beat (func 1) runs through the sequencer states to a loaded result: the
// shared 32x16 multiplier forms the two squares and two cubes in ST_SQ_S,
// ST_CU_S, ST_SQ_D and ST_CU_D, ST_SUM sums and clamps, ST_INTG updates the
// integrator and heater plan, ST_DONE loads the result. in_ch.ready is high
// only while the sequencer is idle: no new beat before the last is loaded.
// Reset clears the plan, counters, integrator and last balance, marks both
// stored temperatures invalid and sets the setpoint to zero. When the
// receiver stalls, the result register holds its beat; the sequencer runs
// the next item but waits in its last step until the register is free.

module heater_balance_controller_core import hbc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic signed [TempW-1:0] cfg_wdata_i,
  hbc_in_if.sink                  in_ch,
  hbc_out_if.source               out_ch
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SQ_S = 8'b0000_0010,
    ST_CU_S = 8'b0000_0100,
    ST_SQ_D = 8'b0000_1000,
    ST_CU_D = 8'b0001_0000,
    ST_SUM  = 8'b0010_0000,
    ST_INTG = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_e;

  localparam logic signed [WideW-1:0] WidePos = WideW'(ClampLimit);
  localparam logic signed [WideW-1:0] WideNeg = -WidePos;
  localparam logic signed [DiffW-1:0] HalfPos = DiffW'(ClampLimit);
  localparam logic signed [DiffW-1:0] HalfNeg = -HalfPos;

  state_e state_q, state_d;

  logic signed [TempW-1:0]  setpoint_q;
  logic signed [TempW-1:0]  cur_q, prev_q;
  logic signed [TempW-1:0]  lb_q, lb_d;
  logic signed [IntegW-1:0] integ_q, integ_d;
  logic        [ProdW-1:0]  s3_q;
  logic                     out_valid_q;
  logic        [PlanW-1:0]  out_plan_q;
  logic signed [TempW-1:0]  out_bal_q;

  logic                     accept;
  logic                     out_free;
  logic signed [DiffW-1:0]  s_val, d_val, s_neg, d_neg;
  logic        [MagW-1:0]   s_mag, d_mag;
  logic        [SqW-1:0]    mul_a;
  logic        [MagW-1:0]   mul_b;
  logic        [ProdW-1:0]  prod;
  logic signed [WideW-1:0]  s_term, d_term, bal_wide;
  logic signed [IntegW-1:0] isum;
  logic signed [DiffW-1:0]  half;
  logic                     over, under;
  plan_cmd_t                cmd;
  logic        [PlanW-1:0]  plan;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_q || out_ch.ready;

  // signed differences and their magnitudes
  assign s_val = {cur_q[TempW-1], cur_q} - {setpoint_q[TempW-1], setpoint_q};
  assign d_val = {cur_q[TempW-1], cur_q} - {prev_q[TempW-1], prev_q};
  assign s_neg = -s_val;
  assign d_neg = -d_val;
  assign s_mag = s_val[DiffW-1] ? s_neg[MagW-1:0] : s_val[MagW-1:0];
  assign d_mag = d_val[DiffW-1] ? d_neg[MagW-1:0] : d_val[MagW-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ_S: begin
        mul_a = SqW'(s_mag);
        mul_b = s_mag;
      end
      ST_CU_S: begin
        mul_a = prod[SqW-1:0];
        mul_b = s_mag;
      end
      ST_SQ_D: begin
        mul_a = SqW'(d_mag);
        mul_b = d_mag;
      end
      ST_CU_D: begin
        mul_a = prod[SqW-1:0];
        mul_b = d_mag;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  hbc_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  // cube sum and clamp
  always_comb begin
    s_term = $signed(WideW'(s3_q));
    if (s_val[DiffW-1]) s_term = -s_term;
    d_term = $signed({2'b00, prod, {SlopeSh{1'b0}}});
    if (d_val[DiffW-1]) d_term = -d_term;
    bal_wide = s_term + d_term;
    if (bal_wide > WidePos) begin
      lb_d = TempW'(WidePos);
    end else if (bal_wide < WideNeg) begin
      lb_d = TempW'(WideNeg);
    end else begin
      lb_d = bal_wide[TempW-1:0];
    end
  end

  // integrator and threshold events
  assign isum  = integ_q + IntegW'(lb_q);
  assign half  = isum[IntegW-1:1];
  assign over  = half > HalfPos;
  assign under = half < HalfNeg;

  always_comb begin
    state_d      = state_q;
    integ_d      = integ_q;
    cmd.tick     = 1'b0;
    cmd.turn_off = 1'b0;
    cmd.turn_on  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.func) begin
            state_d = ST_SQ_S;
          end else begin
            cmd.tick = 1'b1;
            state_d  = ST_DONE;
          end
        end
      end
      ST_SQ_S: state_d = ST_CU_S;
      ST_CU_S: state_d = ST_SQ_D;
      ST_SQ_D: state_d = ST_CU_D;
      ST_CU_D: state_d = ST_SUM;
      ST_SUM:  state_d = ST_INTG;
      ST_INTG: begin
        cmd.turn_off = over;
        cmd.turn_on  = under;
        integ_d      = (over || under) ? '0 : isum;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  hbc_plan u_plan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .plan_o (plan)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      setpoint_q  <= '0;
      cur_q       <= InvalidMark;
      prev_q      <= InvalidMark;
      lb_q        <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      integ_q <= integ_d;
      if (cfg_we_i) setpoint_q <= cfg_wdata_i;
      if (accept && in_ch.func) begin
        if (cur_q != InvalidMark) prev_q <= cur_q;
        cur_q <= in_ch.temperature;
      end
      if (state_q == ST_SUM) lb_q <= lb_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SQ_D) s3_q <= prod;
    if (state_q == ST_DONE && out_free) begin
      out_plan_q <= plan;
      out_bal_q  <= lb_q;
    end
  end

  assign in_ch.ready      = (state_q == ST_IDLE);
  assign out_ch.valid     = out_valid_q;
  assign out_ch.heater_on = out_plan_q;
  assign out_ch.balance   = out_bal_q;

  a_sample_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_ch.func) |-> ##7 (state_q == ST_DONE))
    else $error("sample did not reach the result step in time");

  a_balance_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lb_q != -16'sd32768)
    else $error("clamped balance out of range");

  a_integ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q <= 18'sd65535) && (integ_q >= -18'sd65534))
    else $error("integrator left its retained range");

  a_plan_one_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(plan ^ $past(plan)) <= 1)
    else $error("more than one heater changed in one step");

endmodule

// File: verif/hbc_balance_checker.sv
// hbc_balance_checker: watches the sample and result channels of the heater balance controller,
// predicts every result beat and compares it field by field; depends on hbc_pkg and hbc_if
`timescale 1ns / 1ps

module hbc_balance_checker import hbc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic signed [TempW-1:0] cfg_wdata_i,
  hbc_in_if                       in_ch,
  hbc_out_if                      out_ch,
  output int                      err_cnt_o,
  output int                      pend_cnt_o
);

  localparam logic FuncSample = 1'b1;

  typedef struct packed {
    logic        [PlanW-1:0] heater_on;
    logic signed [TempW-1:0] balance;
  } heater_beat_t;

  heater_beat_t want_q[$];

  logic signed [TempW-1:0] setpoint_q;
  logic        [TempW-1:0] cur_temp_q;
  logic        [TempW-1:0] prev_temp_q;
  int                      integ_q;
  logic        [PlanW-1:0] plan_q;
  logic       [CountW-1:0] runs_q [2];
  logic signed [TempW-1:0] last_bal_q;

  always @(posedge clk_i or negedge rst_ni) begin : watch
    heater_beat_t want;
    heater_beat_t got;
    longint tv, lv, dv, sv, raw;
    int half;
    int pick;
    if (!rst_ni) begin
      want_q.delete();
      err_cnt_o   = 0;
      pend_cnt_o  = 0;
      setpoint_q  = '0;
      cur_temp_q  = InvalidMark;
      prev_temp_q = InvalidMark;
      integ_q     = 0;
      plan_q      = '0;
      runs_q[0]   = '0;
      runs_q[1]   = '0;
      last_bal_q  = '0;
    end else begin
      if (cfg_we_i) begin
        setpoint_q = cfg_wdata_i;
      end

      // result side first: a beat leaving now never belongs to the one entering now
      if (out_ch.valid && out_ch.ready) begin
        got.heater_on = out_ch.heater_on;
        got.balance   = out_ch.balance;
        if (want_q.size() == 0) begin
          err_cnt_o++;
          if (err_cnt_o <= 10) begin
            $display("%0t: unexpected result beat heater_on %0d balance %0d",
                     $realtime, got.heater_on, got.balance);
          end
        end else begin
          want = want_q.pop_front();
          pend_cnt_o--;
          if (got.heater_on !== want.heater_on || got.balance !== want.balance) begin
            err_cnt_o++;
            if (err_cnt_o <= 10) begin
              $display("%0t: result mismatch heater_on exp %0d got %0d, balance exp %0d got %0d",
                       $realtime, want.heater_on, got.heater_on, want.balance, got.balance);
            end
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.func == FuncSample) begin
          if (cur_temp_q != InvalidMark) begin
            prev_temp_q = cur_temp_q;
          end
          cur_temp_q = in_ch.temperature;
          tv  = longint'($signed(cur_temp_q));
          lv  = longint'($signed(prev_temp_q));
          dv  = tv - lv;
          sv  = tv - longint'(setpoint_q);
          raw = sv * sv * sv + ((dv * dv * dv) <<< SlopeSh);
          if (raw > ClampLimit) begin
            raw = ClampLimit;
          end else if (raw < -ClampLimit) begin
            raw = -ClampLimit;
          end
          last_bal_q = TempW'(raw);
          integ_q    = integ_q + int'(raw);
          half       = integ_q >>> 1;
          if (half > ClampLimit) begin
            // drop the heater that is on with the longer run time, heater one on a tie
            pick = -1;
            if (plan_q[0]) pick = 0;
            if (plan_q[1] && (pick < 0 || runs_q[1] > runs_q[0])) pick = 1;
            if (pick >= 0) plan_q[pick] = 1'b0;
            integ_q = 0;
          end else if (half < -ClampLimit) begin
            pick = -1;
            if (!plan_q[0]) pick = 0;
            if (!plan_q[1] && (pick < 0 || runs_q[1] < runs_q[0])) pick = 1;
            if (pick >= 0) plan_q[pick] = 1'b1;
            integ_q = 0;
          end
        end else begin
          if (plan_q[0]) runs_q[0] = runs_q[0] + 1'b1;
          if (plan_q[1]) runs_q[1] = runs_q[1] + 1'b1;
        end
        want.heater_on = plan_q;
        want.balance   = last_bal_q;
        want_q.push_back(want);
        pend_cnt_o++;
      end
    end
  end

endmodule

// File: verif/tb_heater_balance_controller_core.sv
// tb_heater_balance_controller_core: directed and random sample and tick beats under several
// setpoints with random idling on both channels; depends on hbc_pkg, hbc_if, the core and the checker
`timescale 1ns / 1ps

module tb_heater_balance_controller_core;
  import hbc_pkg::*;

  localparam logic FuncTick   = 1'b0;
  localparam logic FuncSample = 1'b1;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i;
  logic signed [TempW-1:0] cfg_wdata_i;
  logic signed [TempW-1:0] setpoint_now;
  bit                      calm;
  int                      err_cnt;
  int                      pend_cnt;

  hbc_in_if  in_ch ();
  hbc_out_if out_ch ();

  heater_balance_controller_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  hbc_balance_checker balance_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .err_cnt_o   (err_cnt),
    .pend_cnt_o  (pend_cnt)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 28);
  end

  task automatic send_beat(input logic func, input logic [TempW-1:0] temp);
    while (!calm && $urandom_range(99) < 28) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= func;
    in_ch.temperature <= temp;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pend_cnt == 0);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_setpoint(input logic signed [TempW-1:0] value);
    drain();
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= value;
    setpoint_now  = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_repeat(input logic func, input logic [TempW-1:0] temp, input int n);
    repeat (n) send_beat(func, temp);
  endtask

  // mostly samples drifting slowly around the setpoint, plus ticks and raw noise
  task automatic run_phase(input int n);
    int drift;
    int r;
    drift = int'($urandom_range(80)) - 40;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 20) begin
        send_beat(FuncTick, TempW'($urandom));
      end else if (r < 23) begin
        send_beat(FuncSample, InvalidMark);
      end else if (r < 33) begin
        send_beat(FuncSample, TempW'($urandom));
      end else begin
        drift = drift + int'($urandom_range(2)) - 1;
        if (drift > 48) drift = 48;
        if (drift < -48) drift = -48;
        send_beat(FuncSample,
                  TempW'(int'(setpoint_now) + drift + int'($urandom_range(2)) - 1));
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("tb_heater_balance_controller_core: errors");
    $finish;
  end

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.func        <= FuncTick;
    in_ch.temperature <= '0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    setpoint_now       = '0;
    calm               = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ticks before any sample, invalid first samples, heaters switched on one by one
    send_repeat(FuncTick, 16'h0000, 2);
    send_repeat(FuncSample, InvalidMark, 2);
    send_beat(FuncSample, 16'h8001);
    send_repeat(FuncTick, 16'hffff, 3);
    send_repeat(FuncSample, InvalidMark, 3);
    send_repeat(FuncTick, 16'h1234, 2);
    send_repeat(FuncSample, InvalidMark, 3);
    send_repeat(FuncSample, 16'h7fff, 3);
    send_beat(FuncSample, 16'h0000);
    send_beat(FuncSample, 16'h0001);
    send_beat(FuncSample, 16'hffff);
    send_beat(FuncSample, 16'h0100);

    write_setpoint(16'sh7fff);
    run_phase(100);
    write_setpoint(-16'sh8000);
    run_phase(100);
    write_setpoint(16'sh0000);
    run_phase(100);
    write_setpoint(TempW'($urandom));
    run_phase(100);
    write_setpoint(TempW'($urandom));
    calm = 1'b1;
    run_phase(100);
    calm = 1'b0;
    write_setpoint(16'sh0100);
    run_phase(100);
    write_setpoint(TempW'($urandom));
    run_phase(100);

    drain();
    if (err_cnt == 0) begin
      $display("tb_heater_balance_controller_core: clean");
    end else begin
      $display("tb_heater_balance_controller_core: errors");
    end
    $finish;
  end

endmodule
